### design/assert_macros.svh
// Assertion macros used by the port checker file of the allocator.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### design/ffha_pkg.sv
// Package of the first-fit header allocator: widths, codes, control word
// types and the microcode table. Depends on nothing.
package ffha_pkg;

	localparam int HEAP_WORDS = 4096;
	localparam int ADDR_W = 12;
	localparam int WORD_W = 13;
	localparam int IDX_W = 14;
	localparam int LIM_W = 15;
	localparam int STEP_W = 4;
	localparam int COND_W = 4;

	localparam logic [WORD_W-1:0] HEAP_WORDS_W = WORD_W'(HEAP_WORDS);
	localparam logic [WORD_W-1:0] MARK_FREE = '0;
	localparam logic [WORD_W-1:0] MARK_USED = WORD_W'(1);
	localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(HEAP_WORDS - 1);

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE = 1'b1;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_OOM = 1'b1;

	// Sequencer steps.
	localparam logic [STEP_W-1:0] S_CLEAR = 4'd0;
	localparam logic [STEP_W-1:0] S_IDLE = 4'd1;
	localparam logic [STEP_W-1:0] S_DISPATCH = 4'd2;
	localparam logic [STEP_W-1:0] S_CHECK = 4'd3;
	localparam logic [STEP_W-1:0] S_RD_SIZE = 4'd4;
	localparam logic [STEP_W-1:0] S_LATCH = 4'd5;
	localparam logic [STEP_W-1:0] S_FIT = 4'd6;
	localparam logic [STEP_W-1:0] S_ZERO = 4'd7;
	localparam logic [STEP_W-1:0] S_ADV = 4'd8;
	localparam logic [STEP_W-1:0] S_FAIL = 4'd9;
	localparam logic [STEP_W-1:0] S_GRANT = 4'd10;
	localparam logic [STEP_W-1:0] S_GRANT2 = 4'd11;
	localparam logic [STEP_W-1:0] S_FREE = 4'd12;
	localparam logic [STEP_W-1:0] S_OUT = 4'd13;
	localparam logic [STEP_W-1:0] S_OUT_WAIT = 4'd14;

	// Jump conditions.
	localparam logic [COND_W-1:0] C_NEVER = 4'd0;
	localparam logic [COND_W-1:0] C_ALWAYS = 4'd1;
	localparam logic [COND_W-1:0] C_CLR_BUSY = 4'd2;
	localparam logic [COND_W-1:0] C_NO_IN = 4'd3;
	localparam logic [COND_W-1:0] C_MODE_FREE = 4'd4;
	localparam logic [COND_W-1:0] C_WALK_END = 4'd5;
	localparam logic [COND_W-1:0] C_MARK_USED = 4'd6;
	localparam logic [COND_W-1:0] C_FIT = 4'd7;
	localparam logic [COND_W-1:0] C_SIZE_ZERO = 4'd8;
	localparam logic [COND_W-1:0] C_OUT_FREE = 4'd9;

	typedef struct packed {
		logic clr;
		logic accept;
		logic rd_mark;
		logic rd_size;
		logic latch_size;
		logic adv;
		logic wr_mark;
		logic wr_size;
		logic wr_free;
		logic res_ok;
		logic res_fail;
		logic res_free;
		logic load_out;
	} ctrl_t;

	typedef struct packed {
		logic clr_busy;
		logic in_fire;
		logic mode_free;
		logic walk_end;
		logic mark_used;
		logic fit;
		logic size_zero;
		logic out_free;
	} flags_t;

	typedef struct packed {
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
		ctrl_t ctrl;
	} ucode_t;

	// The microprogram: a taken condition jumps to target, otherwise the
	// step counter advances by one.
	function automatic ucode_t ucode_word(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '0;
		w.cond = C_NEVER;
		w.target = S_IDLE;
		case (step)
			S_CLEAR: begin
				w.ctrl.clr = 1'b1;
				w.cond = C_CLR_BUSY;
				w.target = S_CLEAR;
			end
			S_IDLE: begin
				w.ctrl.accept = 1'b1;
				w.cond = C_NO_IN;
				w.target = S_IDLE;
			end
			S_DISPATCH: begin
				w.cond = C_MODE_FREE;
				w.target = S_FREE;
			end
			S_CHECK: begin
				w.ctrl.rd_mark = 1'b1;
				w.cond = C_WALK_END;
				w.target = S_FAIL;
			end
			S_RD_SIZE: begin
				w.ctrl.rd_size = 1'b1;
			end
			S_LATCH: begin
				w.ctrl.latch_size = 1'b1;
				w.cond = C_MARK_USED;
				w.target = S_ADV;
			end
			S_FIT: begin
				w.cond = C_FIT;
				w.target = S_GRANT;
			end
			S_ZERO: begin
				w.cond = C_SIZE_ZERO;
				w.target = S_FAIL;
			end
			S_ADV: begin
				w.ctrl.adv = 1'b1;
				w.cond = C_ALWAYS;
				w.target = S_CHECK;
			end
			S_FAIL: begin
				w.ctrl.res_fail = 1'b1;
				w.cond = C_ALWAYS;
				w.target = S_OUT;
			end
			S_GRANT: begin
				w.ctrl.wr_mark = 1'b1;
			end
			S_GRANT2: begin
				w.ctrl.wr_size = 1'b1;
				w.ctrl.res_ok = 1'b1;
				w.cond = C_ALWAYS;
				w.target = S_OUT;
			end
			S_FREE: begin
				w.ctrl.wr_free = 1'b1;
				w.ctrl.res_free = 1'b1;
			end
			S_OUT: begin
				w.ctrl.load_out = 1'b1;
				w.cond = C_OUT_FREE;
				w.target = S_IDLE;
			end
			S_OUT_WAIT: begin
				w.cond = C_ALWAYS;
				w.target = S_OUT;
			end
			default: begin
				w.cond = C_ALWAYS;
				w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

### design/ffha_cmd_if.sv
// Request channel of the allocator: valid/ready handshake plus payload.
// Depends on ffha_pkg.
interface ffha_cmd_if import ffha_pkg::*; ();
	logic valid;
	logic ready;
	logic mode;
	logic [ADDR_W-1:0] request_size;
	logic [ADDR_W-1:0] free_address;

	modport source(output valid, output mode, output request_size, output free_address,
		input ready);
	modport sink(input valid, input mode, input request_size, input free_address,
		output ready);
endinterface

### design/ffha_rsp_if.sv
// Result channel of the allocator: valid/ready handshake plus payload.
// Depends on ffha_pkg.
interface ffha_rsp_if import ffha_pkg::*; ();
	logic valid;
	logic ready;
	logic [ADDR_W-1:0] data_address;
	logic status;

	modport source(output valid, output data_address, output status, input ready);
	modport sink(input valid, input data_address, input status, output ready);
endinterface

### design/ffha_sequencer.sv
// Microcode sequencer: step counter, control table lookup and jump logic.
// Depends on ffha_pkg.
module ffha_sequencer import ffha_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output ctrl_t  ctrl
);

	logic [STEP_W-1:0] step_q;
	ucode_t word;
	logic taken;

	assign word = ucode_word(step_q);
	assign ctrl = word.ctrl;

	always_comb begin
		case (word.cond)
			C_NEVER:     taken = 1'b0;
			C_ALWAYS:    taken = 1'b1;
			C_CLR_BUSY:  taken = flags.clr_busy;
			C_NO_IN:     taken = !flags.in_fire;
			C_MODE_FREE: taken = flags.mode_free;
			C_WALK_END:  taken = flags.walk_end;
			C_MARK_USED: taken = flags.mark_used;
			C_FIT:       taken = flags.fit;
			C_SIZE_ZERO: taken = flags.size_zero;
			C_OUT_FREE:  taken = flags.out_free;
			default:     taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_CLEAR;
		end else if (taken) begin
			step_q <= word.target;
		end else begin
			step_q <= step_q + STEP_W'(1);
		end
	end

endmodule

### design/ffha_datapath.sv
// Datapath of the allocator: heap memory, walk index, compares and the
// result register. Driven by the sequencer's control word; depends on ffha_pkg.
module ffha_datapath import ffha_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctrl,
	output flags_t            flags,
	input  logic              cfg_we,
	input  logic [WORD_W-1:0] cfg_data,
	ffha_cmd_if.sink          cmd,
	ffha_rsp_if.source        rsp
);

	logic [WORD_W-1:0] heap_mem [HEAP_WORDS];
	logic [WORD_W-1:0] rd_q;
	logic [ADDR_W-1:0] clr_q;
	logic [WORD_W-1:0] heap_size_q;
	logic              mode_q;
	logic [ADDR_W-1:0] req_q;
	logic [ADDR_W-1:0] faddr_q;
	logic [IDX_W-1:0]  idx_q;
	logic [WORD_W-1:0] mark_q;
	logic [WORD_W-1:0] size_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              res_status_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic              out_status_q;

	logic [WORD_W-1:0] limit;
	logic [LIM_W-1:0]  hdr_end;
	logic [IDX_W-1:0]  idx_p1;
	logic [IDX_W-1:0]  idx_p2;
	logic [WORD_W-1:0] faddr_m2;
	logic              free_ok;
	logic              in_fire;
	logic              out_busy;
	logic              we;
	logic [ADDR_W-1:0] wa;
	logic [WORD_W-1:0] wd;
	logic [ADDR_W-1:0] ra;

	assign limit = (heap_size_q > HEAP_WORDS_W) ? HEAP_WORDS_W : heap_size_q;
	assign idx_p1 = idx_q + IDX_W'(1);
	assign idx_p2 = idx_q + IDX_W'(2);
	assign hdr_end = LIM_W'(idx_p2);
	assign faddr_m2 = WORD_W'(faddr_q) - WORD_W'(2);
	assign free_ok = (faddr_q >= ADDR_W'(2)) && (faddr_m2 < limit);

	assign cmd.ready = ctrl.accept;
	assign in_fire = ctrl.accept && cmd.valid;
	assign out_busy = out_valid_q && !rsp.ready;

	assign flags.clr_busy = (clr_q != LAST_WORD);
	assign flags.in_fire = in_fire;
	assign flags.mode_free = (mode_q == MODE_FREE);
	assign flags.walk_end = (hdr_end >= LIM_W'(limit));
	assign flags.mark_used = (mark_q != MARK_FREE);
	assign flags.size_zero = (size_q == '0);
	assign flags.out_free = !out_busy;
	// A never-used header must leave room for the request inside the heap.
	assign flags.fit = (size_q == '0) ?
		((hdr_end + LIM_W'(req_q)) <= LIM_W'(limit)) :
		(size_q >= WORD_W'(req_q));

	always_comb begin
		we = 1'b0;
		wa = clr_q;
		wd = MARK_FREE;
		if (ctrl.clr) begin
			we = 1'b1;
		end else if (ctrl.wr_mark) begin
			we = 1'b1;
			wa = idx_q[ADDR_W-1:0];
			wd = MARK_USED;
		end else if (ctrl.wr_size) begin
			we = 1'b1;
			wa = idx_p1[ADDR_W-1:0];
			wd = WORD_W'(req_q);
		end else if (ctrl.wr_free) begin
			we = free_ok;
			wa = faddr_m2[ADDR_W-1:0];
		end
	end

	assign ra = ctrl.rd_size ? idx_p1[ADDR_W-1:0] : idx_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			heap_mem[wa] <= wd;
		end
		rd_q <= heap_mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			heap_size_q <= HEAP_WORDS_W;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.clr) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cfg_we) begin
				heap_size_q <= cfg_data;
			end
			if (ctrl.load_out && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q <= cmd.mode;
			req_q <= cmd.request_size;
			faddr_q <= cmd.free_address;
			idx_q <= '0;
		end else if (ctrl.adv) begin
			idx_q <= idx_p2 + IDX_W'(size_q);
		end
		if (ctrl.rd_size) begin
			mark_q <= rd_q;
		end
		if (ctrl.latch_size) begin
			size_q <= rd_q;
		end
		if (ctrl.res_ok) begin
			res_addr_q <= idx_p2[ADDR_W-1:0];
			res_status_q <= STATUS_OK;
		end else if (ctrl.res_fail) begin
			res_addr_q <= '0;
			res_status_q <= STATUS_OOM;
		end else if (ctrl.res_free) begin
			res_addr_q <= '0;
			res_status_q <= STATUS_OK;
		end
		if (ctrl.load_out && !out_busy) begin
			out_addr_q <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data_address = out_addr_q;
	assign rsp.status = out_status_q;

endmodule

### design/first_fit_header_allocator_core.sv
// First-fit heap allocator with two-word block headers, top level.
// Depends on ffha_pkg, ffha_cmd_if, ffha_rsp_if, ffha_sequencer, ffha_datapath.
//
// Usage: requests arrive on the cmd channel (mode 0 allocate request_size
// words, mode 1 free the block whose data starts at free_address). Every
// request gives exactly one transaction on the rsp channel: the first data
// index and status 0 on a grant, address 0 and status 1 when nothing fits,
// address 0 and status 0 for a free. heap_size is written through cfg_we and
// cfg_data while no request is in flight.
// After reset the sequencer sweeps all 4096 heap words to zero, one word a
// cycle, with cmd.ready low during the sweep; heap_size resets to 4096.
// Requests are handled one at a time by a microprogram over a heap memory
// with one write and one read port. A free runs the dispatch and free steps;
// an allocate that runs off the end of the heap runs dispatch, check and fail.
// One that grants or stops at a never-used header that is too small also
// reads the header (check, read-size, latch, fit), then grants or fails.
// Each header passed adds check, read-size, latch and advance, plus fit and
// zero when it is free but too small; each costs two memory reads. Every path
// ends in the output step; cmd.ready returns in the cycle after the load.
// The result sits in an output register; while the receiver stalls the
// sequencer holds in its output steps and takes no new transaction.
module first_fit_header_allocator_core import ffha_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ffha_cmd_if.sink          cmd,
	ffha_rsp_if.source        rsp,
	input  logic              cfg_we,
	input  logic [WORD_W-1:0] cfg_data
);

	// Control word from the microcode table, and the status flags it jumps on.
	ctrl_t  ctrl;
	flags_t flags;

	ffha_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	// The datapath owns the heap memory, the walk index and the result
	// register that decouples the sequencer from the receiver.
	ffha_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.flags    (flags),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.rsp      (rsp)
	);

endmodule

### design/ffha_checker.sv
// Port-level checks for the allocator top level, attached by bind.
// Depends on ffha_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffha_checker import ffha_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [ADDR_W-1:0] rsp_data_address,
	input logic              rsp_status
);

	`FFHA_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`FFHA_ASSERT_IMP(a_fail_addr_zero, clk, arst_n, rsp_valid && rsp_status == STATUS_OOM, rsp_data_address == '0)
	`FFHA_ASSERT_IMP(a_grant_past_header, clk, arst_n, rsp_valid, rsp_data_address == '0 || rsp_data_address >= ADDR_W'(2))
	`FFHA_ASSERT_NXT(a_one_in_flight, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready)

endmodule

bind first_fit_header_allocator_core ffha_checker u_ffha_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_data_address (rsp.data_address),
	.rsp_status       (rsp.status)
);

### tb/sv/ffha_alloc_checker.sv
// Checker for the first-fit header allocator: watches both channels and the heap_size
// port, keeps its own heap image and compares every result transaction.
// Depends on ffha_pkg, ffha_cmd_if and ffha_rsp_if.
module ffha_alloc_checker import ffha_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ffha_cmd_if               cmd,
	ffha_rsp_if               rsp,
	input  logic              cfg_we,
	input  logic [WORD_W-1:0] cfg_data,
	output int unsigned       mismatches,
	output int unsigned       outstanding
);

	typedef struct packed {
		logic [ADDR_W-1:0] data_address;
		logic              status;
	} grant_t;

	logic [WORD_W-1:0] heap_image [HEAP_WORDS];
	logic [WORD_W-1:0] heap_words_reg;
	grant_t            pending_grants[$];

	// The heap_size register is clamped to the physical store.
	function automatic int unsigned usable_words();
		if (heap_words_reg > HEAP_WORDS_W)
			return HEAP_WORDS;
		return int'(heap_words_reg);
	endfunction

	// First-fit walk over the headers; updates the heap image on a grant.
	function automatic grant_t place_block(input logic [ADDR_W-1:0] want);
		int unsigned lim;
		int unsigned pos;
		int unsigned span;
		grant_t      g;
		lim = usable_words();
		pos = 0;
		g.data_address = '0;
		g.status = STATUS_OOM;
		while (pos + 2 < lim) begin
			span = heap_image[pos + 1];
			if (heap_image[pos] == MARK_FREE) begin
				if ((span == 0 && pos + 2 + want <= lim) || (span != 0 && span >= want)) begin
					heap_image[pos] = MARK_USED;
					heap_image[pos + 1] = WORD_W'(want);
					g.data_address = ADDR_W'(pos + 2);
					g.status = STATUS_OK;
					return g;
				end
				// A never-used header that is too small ends the walk.
				if (span == 0)
					return g;
			end
			pos += span + 2;
		end
		return g;
	endfunction

	function automatic grant_t release_block(input logic [ADDR_W-1:0] where);
		grant_t g;
		g.data_address = '0;
		g.status = STATUS_OK;
		if (where >= 2 && int'(where) - 2 < usable_words())
			heap_image[where - 2] = MARK_FREE;
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		grant_t got;
		if (!arst_n) begin
			foreach (heap_image[k])
				heap_image[k] = MARK_FREE;
			heap_words_reg = HEAP_WORDS_W;
			pending_grants.delete();
			mismatches = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.data_address = rsp.data_address;
				got.status = rsp.status;
				if (pending_grants.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: data_address %0d status %0d",
							got.data_address, got.status);
					mismatches++;
				end else begin
					want = pending_grants.pop_front();
					if (got.data_address !== want.data_address || got.status !== want.status) begin
						if (mismatches < 10)
							$display("result mismatch: data_address %0d status %0d, expected %0d %0d",
								got.data_address, got.status, want.data_address, want.status);
						mismatches++;
					end
				end
			end
			if (cfg_we)
				heap_words_reg = cfg_data;
			if (cmd.valid && cmd.ready) begin
				if (cmd.mode == MODE_FREE)
					pending_grants.push_back(release_block(cmd.free_address));
				else
					pending_grants.push_back(place_block(cmd.request_size));
			end
		end
		outstanding = pending_grants.size();
	end

endmodule

### tb/sv/tb.sv
// Top of the allocator testbench: clock, reset, request and result stimulus,
// heap_size writes, watchdog and verdict.
// Depends on ffha_pkg, the two channel interfaces, the core and ffha_alloc_checker.
module tb;
	import ffha_pkg::*;

	// A run that accepts nothing on either channel for this many cycles is hung.
	// The longest honest pause is the clearing sweep after reset
	// or a walk over some two thousand headers.
	localparam int STALL_LIMIT = 40000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [WORD_W-1:0] cfg_data;
	int unsigned       mismatch_count;
	int unsigned       awaited;
	int unsigned       quiet_cycles = 0;
	int unsigned       hold_gap = 0;
	logic              steady;

	// Data indexes of blocks granted so far; frees are drawn from here so
	// that most of them hit a real header.
	logic [ADDR_W-1:0] live_blocks[$];

	ffha_cmd_if cmd_ch();
	ffha_rsp_if rsp_ch();

	first_fit_header_allocator_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data)
	);

	ffha_alloc_checker alloc_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.mismatches (mismatch_count),
		.outstanding(awaited)
	);

	always #6 clk = ~clk;

	// The result side stalls in about a quarter of the cycles, except while
	// the steady stretch is running.
	always @(posedge clk) begin
		rsp_ch.ready <= steady || ($urandom_range(99) >= 24);
	end

	// Remember every granted block. A free also answers with status OK, but
	// always at address 0, which no grant can return.
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready && rsp_ch.status == STATUS_OK && rsp_ch.data_address != '0)
			live_blocks.push_back(rsp_ch.data_address);
	end

	// Watchdog: counts cycles in which no transaction moves on either channel.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Presents one request and returns at the edge where it is accepted.
	// The valid line stays high when the next request follows at once, so it
	// is never lowered and raised in the same step; otherwise it drops here
	// and the gap is served at the start of the next call.
	task automatic issue_request(input logic m, input logic [ADDR_W-1:0] want,
		input logic [ADDR_W-1:0] where);
		if (hold_gap > 0)
			repeat (hold_gap) @(posedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= m;
		cmd_ch.request_size <= want;
		cmd_ch.free_address <= where;
		do @(posedge clk); while (!cmd_ch.ready);
		hold_gap = (!steady && $urandom_range(99) < 24) ? $urandom_range(24, 1) : 0;
		if (hold_gap > 0)
			cmd_ch.valid <= 1'b0;
	endtask

	// Drops the request line and waits until every result has come back.
	task automatic settle_block();
		if (hold_gap == 0)
			cmd_ch.valid <= 1'b0;
		hold_gap = 0;
		do @(posedge clk); while (awaited != 0);
		repeat (2) @(posedge clk);
	endtask

	// heap_size may only change while nothing is in flight.
	task automatic set_heap_size(input logic [WORD_W-1:0] words);
		settle_block();
		cfg_we <= 1'b1;
		cfg_data <= words;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random traffic: mostly allocations in the given size band and frees of
	// blocks that were granted, with some frees of arbitrary addresses and
	// allocations of arbitrary size mixed in.
	task automatic random_traffic(input int count, input int unsigned req_lo,
		input int unsigned req_hi);
		int unsigned       pick;
		int unsigned       slot;
		logic [ADDR_W-1:0] where;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 36 && live_blocks.size() != 0) begin
				slot = $urandom_range(live_blocks.size() - 1);
				where = live_blocks[slot];
				live_blocks.delete(slot);
				issue_request(MODE_FREE, ADDR_W'($urandom), where);
			end else if (pick < 44) begin
				issue_request(MODE_FREE, ADDR_W'($urandom), ADDR_W'($urandom));
			end else if (pick < 50) begin
				issue_request(MODE_ALLOC, ADDR_W'($urandom), ADDR_W'($urandom));
			end else begin
				issue_request(MODE_ALLOC, ADDR_W'($urandom_range(req_hi, req_lo)),
					ADDR_W'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		steady = 1'b0;
		cfg_we = 1'b0;
		cfg_data = HEAP_WORDS_W;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = MODE_ALLOC;
		cmd_ch.request_size = '0;
		cmd_ch.free_address = '0;
		rsp_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on the full heap at its reset size. The first request
		// also waits out the clearing sweep.
		issue_request(MODE_ALLOC, 12'd0, 12'd0);          // zero-size block at the start
		issue_request(MODE_ALLOC, 12'd4095, 12'd0);       // never-used header, too big
		issue_request(MODE_ALLOC, 12'd4092, 12'd0);       // fills the heap exactly
		issue_request(MODE_ALLOC, 12'd1, 12'd0);          // walk runs off the end
		issue_request(MODE_FREE, 12'd4095, 12'd4);
		issue_request(MODE_ALLOC, 12'd100, 12'd4095);     // reuse, remainder reads as a never-used header
		issue_request(MODE_ALLOC, 12'd50, 12'd0);
		issue_request(MODE_FREE, 12'd0, 12'd0);           // address below two is ignored
		issue_request(MODE_FREE, 12'd0, 12'd1);
		issue_request(MODE_FREE, 12'd0, 12'd4095);        // highest address
		issue_request(MODE_FREE, 12'd0, 12'd106);
		issue_request(MODE_ALLOC, 12'd51, 12'd0);         // freed block too small, walk on
		issue_request(MODE_ALLOC, 12'd50, 12'd0);         // exact reuse
		issue_request(MODE_FREE, 12'd0, 12'd2);           // frees the zero-size block
		issue_request(MODE_ALLOC, 12'd0, 12'd0);          // freed zero size counts as never used
		issue_request(MODE_ALLOC, 12'd4094, 12'd4095);

		// A heap below three words refuses every allocation; a free still works.
		set_heap_size(13'd2);
		issue_request(MODE_ALLOC, 12'd0, 12'd0);
		issue_request(MODE_FREE, 12'd0, 12'd2);
		issue_request(MODE_ALLOC, 12'd1, 12'd0);
		issue_request(MODE_FREE, 12'd0, 12'd5);           // outside the heap, ignored

		// Smallest legal heap: one header and one data word.
		set_heap_size(13'd3);
		issue_request(MODE_ALLOC, 12'd1, 12'd0);
		random_traffic(36, 0, 3);

		set_heap_size(13'd48);
		random_traffic(150, 0, 12);

		// Steady stretch: neither side idles.
		set_heap_size(13'd200);
		steady = 1'b1;
		random_traffic(200, 0, 40);
		settle_block();
		steady = 1'b0;

		// Largest heap, with large blocks so the walks stay short.
		set_heap_size(HEAP_WORDS_W);
		random_traffic(80, 16, 1024);

		set_heap_size(13'd1000);
		random_traffic(150, 0, 100);

		set_heap_size(13'd37);
		random_traffic(80, 0, 10);

		settle_block();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && awaited == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
